// ===== hw/rtl/wsp_pkg.sv =====
// ============================================================================
// wsp_pkg
// Shared types and constants for the byte-serial RIFF/WAVE PCM parser.
// ============================================================================
package wsp_pkg;

    typedef enum logic [6:0] {
        PH_SIG  = 7'b0000001,
        PH_HDR  = 7'b0000010,
        PH_FMT  = 7'b0000100,
        PH_SKIP = 7'b0001000,
        PH_PAD  = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_DONE = 7'b1000000
    } phase_t;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_SIGNATURE = 4'd1;
    localparam logic [3:0] ERR_FMT_SHORT = 4'd2;
    localparam logic [3:0] ERR_EXT_SHORT = 4'd3;
    localparam logic [3:0] ERR_SUBFORMAT = 4'd4;
    localparam logic [3:0] ERR_NOT_PCM   = 4'd5;
    localparam logic [3:0] ERR_DEPTH     = 4'd6;
    localparam logic [3:0] ERR_CHANNELS  = 4'd7;
    localparam logic [3:0] ERR_DATA_1ST  = 4'd8;
    localparam logic [3:0] ERR_MISSING   = 4'd9;

    localparam logic [31:0]  RIFF_WORD    = 32'h4646_4952;
    localparam logic [31:0]  WAVE_WORD    = 32'h4556_4157;
    localparam logic [31:0]  TAG_FMT      = 32'h2074_6D66;
    localparam logic [31:0]  TAG_DATA     = 32'h6174_6164;
    localparam logic [15:0]  FMT_PCM      = 16'h0001;
    localparam logic [15:0]  FMT_EXT      = 16'hFFFE;
    localparam logic [127:0] PCM_GUID     = 128'h719B3800_AA000080_00100000_00000001;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] sample;
        logic [3:0]  error_code;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [4:0]  bits_per_sample;
        logic [2:0]  container_bytes;
        logic        last_of_run;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic res_t mk_res(input logic [1:0] kind, input logic [23:0] smp,
                                    input logic [3:0] err, input logic found,
                                    input logic [15:0] chan, input logic [31:0] rate,
                                    input logic [15:0] depth, input logic [2:0] slot);
        res_t r;
        r.kind            = kind;
        r.sample          = smp;
        r.error_code      = err;
        r.num_channels    = found ? chan : 16'd0;
        r.sample_rate     = found ? rate : 32'd0;
        r.bits_per_sample = found ? depth[4:0] : 5'd0;
        r.container_bytes = found ? slot : 3'd0;
        r.last_of_run     = 1'b0;
        return r;
    endfunction

endpackage

// ===== hw/rtl/wav_stream_parser_top.sv =====
// ============================================================================
// wav_stream_parser_top
// Byte-serial RIFF/WAVE PCM parser: signature, chunk walk, fmt decode, samples.
// ============================================================================
//  Channel   Direction  Carries
//  s_        in         one file byte and its end-of-file mark per transaction
//  m_        out        one result (sample, format, finish or error) per transaction
//
//  Each byte is decoded in the cycle it is accepted; one byte per cycle is taken
//  while s_ready is high. A byte yields zero, one or two results into a four-entry
//  result queue, and the first of them is offered on m_ after earlier results leave.
//  s_ready is high while the queue holds at most two results, so a stalled m_
//  side stops input once three or more results wait.
//  aresetn is synchronous and active low; a byte marked end of file rearms the parser.
module wav_stream_parser_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_file_byte,
    input  logic               s_end_of_file,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [23:0] m_sample,
    output logic [3:0]         m_error_code,
    output logic [15:0]        m_num_channels,
    output logic [31:0]        m_sample_rate,
    output logic [4:0]         m_bits_per_sample,
    output logic [2:0]         m_container_bytes,
    output logic               m_last_of_run
);

    wsp_pkg::push_t push;
    wsp_pkg::res_t  head;
    logic           accept;

    assign accept = s_valid && s_ready;

    wsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_byte   (s_file_byte),
        .in_eof    (s_end_of_file),
        .push      (push)
    );

    wsp_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (head)
    );

    assign m_kind            = head.kind;
    assign m_sample          = $signed(head.sample);
    assign m_error_code      = head.error_code;
    assign m_num_channels    = head.num_channels;
    assign m_sample_rate     = head.sample_rate;
    assign m_bits_per_sample = head.bits_per_sample;
    assign m_container_bytes = head.container_bytes;
    assign m_last_of_run     = head.last_of_run;

endmodule

// ===== hw/rtl/wsp_core.sv =====
// ============================================================================
// wsp_core
// Parser state and the per-byte decode that yields up to two results.
// ============================================================================
module wsp_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_accept,
    input  logic [7:0]     in_byte,
    input  logic           in_eof,
    output wsp_pkg::push_t push
);

    wsp_pkg::phase_t phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] tag_reg, tag_next;
    logic        pad_reg, pad_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] depth_reg, depth_next;
    logic [2:0]  slot_reg, slot_next;
    logic        guid_reg, guid_next;
    logic        found_reg, found_next;
    logic [31:0] gath_reg, gath_next;
    logic [2:0]  gcnt_reg, gcnt_next;

    always_comb begin
        logic [5:0]  off;
        logic [1:0]  n;
        logic [15:0] bits;
        logic [15:0] valid;
        logic [7:0]  cont;
        logic [7:0]  vb;
        logic [31:0] u;
        logic [23:0] smp;
        logic        do_acc;
        logic        ext;
        wsp_pkg::res_t r0, r1;
        off = pos_reg;
        n = 2'd0;
        bits = 16'd0;
        valid = 16'd0;
        cont = 8'd0;
        vb = 8'd0;
        u = 32'd0;
        smp = 24'd0;
        do_acc = 1'b0;
        ext = 1'b0;
        r0 = '0;
        r1 = '0;
        phase_next = phase_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        tag_next = tag_reg;
        pad_next = pad_reg;
        ftag_next = ftag_reg;
        chan_next = chan_reg;
        rate_next = rate_reg;
        depth_next = depth_reg;
        slot_next = slot_reg;
        guid_next = guid_reg;
        found_next = found_reg;
        gath_next = gath_reg;
        gcnt_next = gcnt_reg;

        case (phase_reg)
            wsp_pkg::PH_SIG: begin
                if ((off < 6'd4 && in_byte != wsp_pkg::RIFF_WORD[{off[1:0], 3'b000} +: 8])
                    || (off >= 6'd8 && off < 6'd12
                        && in_byte != wsp_pkg::WAVE_WORD[{off[1:0], 3'b000} +: 8])) begin
                    phase_next = wsp_pkg::PH_DONE;
                    r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0, wsp_pkg::ERR_SIGNATURE,
                                         found_next, chan_next, rate_next, depth_next,
                                         slot_next);
                    n = 2'd1;
                end else begin
                    pos_next = off + 6'd1;
                    if (pos_next >= 6'd12) begin
                        phase_next = wsp_pkg::PH_HDR;
                        pos_next = 6'd0;
                        tag_next = 32'd0;
                        len_next = 32'd0;
                    end
                end
            end
            wsp_pkg::PH_HDR: begin
                if (off < 6'd4) begin
                    tag_next = tag_reg | (32'(in_byte) << {off[1:0], 3'b000});
                end else begin
                    len_next = len_reg | (32'(in_byte) << {off[1:0], 3'b000});
                end
                pos_next = off + 6'd1;
                if (pos_next >= 6'd8) begin
                    pad_next = len_next[0];
                    if (tag_next == wsp_pkg::TAG_FMT) begin
                        if (len_next < 32'd16) begin
                            phase_next = wsp_pkg::PH_DONE;
                            r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0,
                                                 wsp_pkg::ERR_FMT_SHORT, found_next, chan_next,
                                                 rate_next, depth_next, slot_next);
                            n = 2'd1;
                        end else begin
                            ftag_next = 16'd0;
                            chan_next = 16'd0;
                            rate_next = 32'd0;
                            depth_next = 16'd0;
                            slot_next = 3'd0;
                            guid_next = 1'b1;
                            gath_next = 32'd0;
                            found_next = 1'b0;
                            pos_next = 6'd0;
                            phase_next = wsp_pkg::PH_FMT;
                        end
                    end else if (tag_next == wsp_pkg::TAG_DATA) begin
                        if (!found_next) begin
                            phase_next = wsp_pkg::PH_DONE;
                            r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0,
                                                 wsp_pkg::ERR_DATA_1ST, found_next, chan_next,
                                                 rate_next, depth_next, slot_next);
                            n = 2'd1;
                        end else begin
                            gath_next = 32'd0;
                            gcnt_next = 3'd0;
                            if (len_next == 32'd0) begin
                                phase_next = wsp_pkg::PH_DONE;
                                r0 = wsp_pkg::mk_res(wsp_pkg::KIND_FINISH, 24'd0,
                                                     wsp_pkg::ERR_NONE, found_next, chan_next,
                                                     rate_next, depth_next, slot_next);
                                n = 2'd1;
                            end else begin
                                phase_next = wsp_pkg::PH_DATA;
                            end
                        end
                    end else if (len_next != 32'd0) begin
                        phase_next = wsp_pkg::PH_SKIP;
                    end else if (pad_next) begin
                        phase_next = wsp_pkg::PH_PAD;
                    end else begin
                        phase_next = wsp_pkg::PH_HDR;
                        pos_next = 6'd0;
                        tag_next = 32'd0;
                        len_next = 32'd0;
                    end
                end
            end
            wsp_pkg::PH_FMT: begin
                len_next = len_reg - 32'd1;
                if (off < 6'd2) begin
                    ftag_next = ftag_reg | (16'(in_byte) << {off[0], 3'b000});
                end else if (off < 6'd4) begin
                    chan_next = chan_reg | (16'(in_byte) << {off[0], 3'b000});
                end else if (off < 6'd8) begin
                    rate_next = rate_reg | (32'(in_byte) << {off[1:0], 3'b000});
                end else if (off == 6'd14 || off == 6'd15) begin
                    depth_next = depth_reg | (16'(in_byte) << {off[0], 3'b000});
                end else if (off == 6'd18 || off == 6'd19) begin
                    gath_next = gath_reg | (32'(in_byte) << {off[0], 3'b000});
                end else if (off >= 6'd24 && off < 6'd40) begin
                    if (in_byte != wsp_pkg::PCM_GUID[{off[3:0] - 4'd8, 3'b000} +: 8]) begin
                        guid_next = 1'b0;
                    end
                end
                pos_next = off + 6'd1;
                if (off == 6'd15) begin
                    if (ftag_next == wsp_pkg::FMT_EXT) begin
                        if (len_next < 32'd24) begin
                            phase_next = wsp_pkg::PH_DONE;
                            r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0,
                                                 wsp_pkg::ERR_EXT_SHORT, found_next, chan_next,
                                                 rate_next, depth_next, slot_next);
                            n = 2'd1;
                        end
                    end else if (ftag_next != wsp_pkg::FMT_PCM) begin
                        phase_next = wsp_pkg::PH_DONE;
                        r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0, wsp_pkg::ERR_NOT_PCM,
                                             found_next, chan_next, rate_next, depth_next,
                                             slot_next);
                        n = 2'd1;
                    end else begin
                        do_acc = 1'b1;
                    end
                end else if (off == 6'd39) begin
                    if (!guid_next) begin
                        phase_next = wsp_pkg::PH_DONE;
                        r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0,
                                             wsp_pkg::ERR_SUBFORMAT, found_next, chan_next,
                                             rate_next, depth_next, slot_next);
                        n = 2'd1;
                    end else begin
                        do_acc = 1'b1;
                        ext = 1'b1;
                    end
                end
                if (do_acc) begin
                    bits = depth_next;
                    if (ext) begin
                        valid = gath_next[15:0];
                        if (valid != 16'd0 && valid != bits) begin
                            cont = bits[10:3];
                            bits = valid;
                        end
                    end
                    vb = 8'(bits[4:3]);
                    if (cont == 8'd0) begin
                        cont = vb;
                    end
                    if (bits != 16'd8 && bits != 16'd16 && bits != 16'd24) begin
                        phase_next = wsp_pkg::PH_DONE;
                        r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0, wsp_pkg::ERR_DEPTH,
                                             found_next, chan_next, rate_next, depth_next,
                                             slot_next);
                    end else if (chan_next == 16'd0) begin
                        phase_next = wsp_pkg::PH_DONE;
                        r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0,
                                             wsp_pkg::ERR_CHANNELS, found_next, chan_next,
                                             rate_next, depth_next, slot_next);
                    end else if (cont < vb || cont > 8'd4) begin
                        phase_next = wsp_pkg::PH_DONE;
                        r0 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0, wsp_pkg::ERR_DEPTH,
                                             found_next, chan_next, rate_next, depth_next,
                                             slot_next);
                    end else begin
                        depth_next = bits;
                        slot_next = cont[2:0];
                        ftag_next = wsp_pkg::FMT_PCM;
                        found_next = 1'b1;
                        gath_next = 32'd0;
                        r0 = wsp_pkg::mk_res(wsp_pkg::KIND_FORMAT, 24'd0, wsp_pkg::ERR_NONE,
                                             found_next, chan_next, rate_next, depth_next,
                                             slot_next);
                        if (len_next != 32'd0) begin
                            phase_next = wsp_pkg::PH_SKIP;
                        end else if (pad_next) begin
                            phase_next = wsp_pkg::PH_PAD;
                        end else begin
                            phase_next = wsp_pkg::PH_HDR;
                            pos_next = 6'd0;
                            tag_next = 32'd0;
                            len_next = 32'd0;
                        end
                    end
                    n = 2'd1;
                end
            end
            wsp_pkg::PH_SKIP: begin
                len_next = len_reg - 32'd1;
                if (len_next == 32'd0) begin
                    if (pad_reg) begin
                        phase_next = wsp_pkg::PH_PAD;
                    end else begin
                        phase_next = wsp_pkg::PH_HDR;
                        pos_next = 6'd0;
                        tag_next = 32'd0;
                    end
                end
            end
            wsp_pkg::PH_PAD: begin
                phase_next = wsp_pkg::PH_HDR;
                pos_next = 6'd0;
                tag_next = 32'd0;
                len_next = 32'd0;
            end
            wsp_pkg::PH_DATA: begin
                len_next = len_reg - 32'd1;
                gath_next = gath_reg | (32'(in_byte) << {gcnt_reg[1:0], 3'b000});
                gcnt_next = gcnt_reg + 3'd1;
                if (gcnt_next >= slot_reg) begin
                    case (slot_reg)
                        3'd1:    u = {gath_next[7:0], 24'd0};
                        3'd2:    u = {gath_next[15:0], 16'd0};
                        3'd3:    u = {gath_next[23:0], 8'd0};
                        default: u = gath_next;
                    endcase
                    case (depth_reg[4:0])
                        5'd8:    smp = (slot_reg == 3'd1) ? {16'd0, u[31:24]}
                                                          : {{16{u[31]}}, u[31:24]};
                        5'd16:   smp = {{8{u[31]}}, u[31:16]};
                        5'd24:   smp = u[31:8];
                        default: smp = 24'd0;
                    endcase
                    r0 = wsp_pkg::mk_res(wsp_pkg::KIND_SAMPLE, smp, wsp_pkg::ERR_NONE,
                                         found_next, chan_next, rate_next, depth_next,
                                         slot_next);
                    n = 2'd1;
                    gath_next = 32'd0;
                    gcnt_next = 3'd0;
                end
                if (len_next == 32'd0) begin
                    phase_next = wsp_pkg::PH_DONE;
                    if (n == 2'd0) begin
                        r0 = wsp_pkg::mk_res(wsp_pkg::KIND_FINISH, 24'd0, wsp_pkg::ERR_NONE,
                                             found_next, chan_next, rate_next, depth_next,
                                             slot_next);
                    end else begin
                        r1 = wsp_pkg::mk_res(wsp_pkg::KIND_FINISH, 24'd0, wsp_pkg::ERR_NONE,
                                             found_next, chan_next, rate_next, depth_next,
                                             slot_next);
                    end
                    n = n + 2'd1;
                end
            end
            default: begin
            end
        endcase

        if (in_eof && phase_next != wsp_pkg::PH_DONE) begin
            if (phase_next == wsp_pkg::PH_DATA) begin
                r1 = wsp_pkg::mk_res(wsp_pkg::KIND_FINISH, 24'd0, wsp_pkg::ERR_NONE,
                                     found_next, chan_next, rate_next, depth_next, slot_next);
            end else if (phase_next == wsp_pkg::PH_SIG) begin
                r1 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0, wsp_pkg::ERR_SIGNATURE,
                                     found_next, chan_next, rate_next, depth_next, slot_next);
            end else if (phase_next == wsp_pkg::PH_FMT) begin
                r1 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0,
                                     (pos_next < 6'd16) ? wsp_pkg::ERR_FMT_SHORT
                                                        : wsp_pkg::ERR_EXT_SHORT,
                                     found_next, chan_next, rate_next, depth_next, slot_next);
            end else begin
                r1 = wsp_pkg::mk_res(wsp_pkg::KIND_ERROR, 24'd0, wsp_pkg::ERR_MISSING,
                                     found_next, chan_next, rate_next, depth_next, slot_next);
            end
            if (n == 2'd0) begin
                r0 = r1;
            end
            n = n + 2'd1;
        end

        if (n == 2'd1) begin
            r0.last_of_run = 1'b1;
        end else begin
            r1.last_of_run = 1'b1;
        end

        if (in_eof) begin
            phase_next = wsp_pkg::PH_SIG;
            pos_next = 6'd0;
            len_next = 32'd0;
            tag_next = 32'd0;
            pad_next = 1'b0;
            ftag_next = 16'd0;
            chan_next = 16'd0;
            rate_next = 32'd0;
            depth_next = 16'd0;
            slot_next = 3'd0;
            guid_next = 1'b1;
            found_next = 1'b0;
            gath_next = 32'd0;
            gcnt_next = 3'd0;
        end

        push.count = in_accept ? n : 2'd0;
        push.r0 = r0;
        push.r1 = r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wsp_pkg::PH_SIG;
            pos_reg   <= 6'd0;
            len_reg   <= 32'd0;
            tag_reg   <= 32'd0;
            pad_reg   <= 1'b0;
            ftag_reg  <= 16'd0;
            chan_reg  <= 16'd0;
            rate_reg  <= 32'd0;
            depth_reg <= 16'd0;
            slot_reg  <= 3'd0;
            guid_reg  <= 1'b1;
            found_reg <= 1'b0;
            gath_reg  <= 32'd0;
            gcnt_reg  <= 3'd0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            tag_reg   <= tag_next;
            pad_reg   <= pad_next;
            ftag_reg  <= ftag_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            depth_reg <= depth_next;
            slot_reg  <= slot_next;
            guid_reg  <= guid_next;
            found_reg <= found_next;
            gath_reg  <= gath_next;
            gcnt_reg  <= gcnt_next;
        end
    end

endmodule

// ===== hw/rtl/wsp_out_fifo.sv =====
// ============================================================================
// wsp_out_fifo
// Four-entry result queue that takes up to two results per cycle.
// ============================================================================
module wsp_out_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  wsp_pkg::push_t push,
    output logic           space_ok,
    output logic           out_valid,
    input  logic           out_ready,
    output wsp_pkg::res_t  out_res
);

    wsp_pkg::res_t mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign space_ok  = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_res   = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = wr_reg + 2'(push.count);
        rd_next  = rd_reg + 2'(pop);
        cnt_next = cnt_reg + 3'(push.count) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/wsp_checker.sv =====
// ============================================================================
// wsp_checker
// Port-level checks on the result channel of the parser.
// ============================================================================
module wsp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_kind,
    input logic signed [23:0] m_sample,
    input logic [3:0]         m_error_code,
    input logic               m_last_of_run
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_sample))
        else $error("Result changed while stalled.");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == wsp_pkg::KIND_ERROR |-> m_error_code != wsp_pkg::ERR_NONE)
        else $error("Error result without a code.");

    a_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != wsp_pkg::KIND_ERROR |-> m_error_code == wsp_pkg::ERR_NONE)
        else $error("Error code on a non-error result.");

    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == wsp_pkg::KIND_ERROR || m_kind == wsp_pkg::KIND_FINISH)
        |-> m_last_of_run && m_sample == 24'sd0)
        else $error("Terminal result not last or carries a sample.");

endmodule

bind wav_stream_parser_top wsp_checker u_wsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_sample      (m_sample),
    .m_error_code  (m_error_code),
    .m_last_of_run (m_last_of_run)
);
